// File: rtl/two_mode_motor_controller_macros.svh
// Assertion macros shared by the two-mode motor controller RTL.
// Each asserting module includes this header; it depends on nothing else.
`ifndef TWO_MODE_MOTOR_CONTROLLER_MACROS_SVH
`define TWO_MODE_MOTOR_CONTROLLER_MACROS_SVH

// Checked on every rising edge of clk, ignored while arst_n is low.
`define MMC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge of clk, also during reset.
`define MMC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/mmc_pkg.sv
// Package for the two-mode motor controller: payload structs, mode codes,
// reset values and the groups of status signals passed between modules.
// No dependencies.
package mmc_pkg;

	localparam int unsigned KeyW   = 5;
	localparam int unsigned KeysW  = 16;
	localparam int unsigned TicksW = 16;
	localparam int unsigned CfgW   = 16;

	localparam logic [1:0] MODE_IDLE   = 2'd0;
	localparam logic [1:0] MODE_TIMING = 2'd1;
	localparam logic [1:0] MODE_CONT   = 2'd2;
	localparam logic [1:0] MODE_WAIT   = 2'd3;

	localparam logic [1:0] GLYPH_OFF = 2'd2;

	localparam logic CFG_PRESS_LIMIT = 1'b0;
	localparam logic CFG_STOP_KEY    = 1'b1;

	localparam logic [TicksW-1:0] PRESS_LIMIT_RST = 16'd50;
	localparam logic [KeyW-1:0]   STOP_KEY_RST    = 5'd3;
	localparam logic [KeyW-1:0]   CHOSEN_KEY_RST  = 5'd3;
	localparam logic [3:0]        PHASE_RST       = 4'b0001;
	localparam logic [TicksW-1:0] TICKS_MAX       = '1;

	typedef struct packed {
		logic             button_down;
		logic [KeysW-1:0] keypad_bits;
	} tick_t;

	typedef struct packed {
		logic       motor_pin_a;
		logic       motor_pin_b;
		logic [3:0] stepper_coils;
		logic       stepper_advanced;
		logic [1:0] glyph_select;
		logic [1:0] mode_now;
	} result_t;

	typedef struct packed {
		logic [3:0] coils;
		logic       advanced;
	} step_status_t;

	typedef struct packed {
		logic       pin_a;
		logic       pin_b;
		logic [1:0] glyph;
		logic [1:0] mode;
	} motor_status_t;

endpackage

// File: rtl/mmc_stepper.sv
// Keypad key selection and stepper phase timing for the motor controller.
// Depends on mmc_pkg and the assertion macros header.
`include "two_mode_motor_controller_macros.svh"

module mmc_stepper (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic [mmc_pkg::KeysW-1:0]    keypad_bits,
	input  logic [mmc_pkg::KeyW-1:0]     stop_key,
	output mmc_pkg::step_status_t        status
);
	import mmc_pkg::*;

	logic [KeyW-1:0]   chosen_q;
	logic [TicksW-1:0] step_ticks_q;
	logic [3:0]        phase_q;
	logic              advanced_q;

	logic              one_hot;
	logic [KeyW-1:0]   key_of_bit;
	logic [KeyW-1:0]   key_next;
	logic              stepping;
	logic              fire;

	always_comb begin
		key_of_bit = '0;
		for (int k = 0; k < KeysW; k++) begin
			if (keypad_bits[k]) begin
				key_of_bit = key_of_bit | KeyW'(k + 1);
			end
		end
	end

	assign one_hot  = (keypad_bits != '0) && ((keypad_bits & (keypad_bits - 1'b1)) == '0);
	assign key_next = one_hot ? key_of_bit : chosen_q;
	assign stepping = (key_next != stop_key);
	assign fire     = stepping && ({{(TicksW-KeyW){1'b0}}, key_next} < step_ticks_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chosen_q     <= CHOSEN_KEY_RST;
			step_ticks_q <= '0;
			phase_q      <= PHASE_RST;
			advanced_q   <= 1'b0;
		end else if (adv) begin
			chosen_q   <= key_next;
			advanced_q <= fire;
			if (fire) begin
				// The phase walks 1, 2, 4, 8 and wraps back to 1.
				phase_q      <= {phase_q[2:0], phase_q[3]};
				step_ticks_q <= '0;
			end else if (stepping && step_ticks_q != TICKS_MAX) begin
				step_ticks_q <= step_ticks_q + 1'b1;
			end
		end
	end

	assign status.coils    = phase_q;
	assign status.advanced = advanced_q;

	`MMC_ASSERT(a_phase_onehot, $onehot(phase_q), "stepper phase is not one-hot")
	`MMC_ASSERT(a_step_clears, advanced_q |-> (step_ticks_q == '0),
		"step counter not cleared after a step")
	`MMC_ASSERT(a_key_range, (chosen_q != '0) && (chosen_q <= 5'd16),
		"selected key out of range")

endmodule

// File: rtl/mmc_button.sv
// Button state machine that times presses and drives the DC motor pins and glyph.
// Depends on mmc_pkg and the assertion macros header.
`include "two_mode_motor_controller_macros.svh"

module mmc_button (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          button_down,
	input  logic [mmc_pkg::TicksW-1:0]    press_limit,
	output mmc_pkg::motor_status_t        status
);
	import mmc_pkg::*;

	logic [1:0]        mode_q;
	logic [TicksW-1:0] press_ticks_q;
	logic              dir_q;
	logic [1:0]        glyph_q;
	logic              pin_a_q;
	logic              pin_b_q;

	logic [1:0]        mode_d;
	logic [TicksW-1:0] press_ticks_d;
	logic [TicksW-1:0] press_inc;
	logic              dir_d;
	logic [1:0]        glyph_d;
	logic              pin_a_d;
	logic              pin_b_d;

	assign press_inc = (press_ticks_q != TICKS_MAX) ? press_ticks_q + 1'b1 : press_ticks_q;

	always_comb begin
		mode_d        = mode_q;
		press_ticks_d = press_ticks_q;
		dir_d         = dir_q;
		glyph_d       = glyph_q;
		pin_a_d       = pin_a_q;
		pin_b_d       = pin_b_q;
		case (mode_q)
			MODE_IDLE: begin
				if (button_down) begin
					// Running left drives A high, running right drives B high.
					pin_a_d       = ~dir_q;
					pin_b_d       = dir_q;
					mode_d        = MODE_TIMING;
					glyph_d       = {1'b0, dir_q};
					press_ticks_d = '0;
				end else begin
					pin_a_d = 1'b1;
					pin_b_d = 1'b1;
					glyph_d = GLYPH_OFF;
				end
			end
			MODE_TIMING: begin
				press_ticks_d = press_inc;
				if (!button_down) begin
					if (press_inc <= press_limit) begin
						mode_d = MODE_CONT;
					end else begin
						dir_d  = ~dir_q;
						mode_d = MODE_IDLE;
					end
				end
			end
			MODE_CONT: begin
				if (button_down) begin
					pin_a_d = 1'b1;
					pin_b_d = 1'b1;
					mode_d  = MODE_WAIT;
				end else begin
					pin_a_d = ~dir_q;
					pin_b_d = dir_q;
				end
			end
			default: begin
				if (!button_down) begin
					mode_d = MODE_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_IDLE;
			press_ticks_q <= '0;
			dir_q         <= 1'b1;
			glyph_q       <= GLYPH_OFF;
			pin_a_q       <= 1'b1;
			pin_b_q       <= 1'b1;
		end else if (adv) begin
			mode_q        <= mode_d;
			press_ticks_q <= press_ticks_d;
			dir_q         <= dir_d;
			glyph_q       <= glyph_d;
			pin_a_q       <= pin_a_d;
			pin_b_q       <= pin_b_d;
		end
	end

	assign status.pin_a = pin_a_q;
	assign status.pin_b = pin_b_q;
	assign status.glyph = glyph_q;
	assign status.mode  = mode_q;

	`MMC_ASSERT(a_cont_drives, (mode_q == MODE_CONT) |-> (pin_a_q != pin_b_q),
		"motor not driven while running continuously")
	`MMC_ASSERT(a_wait_stopped, (mode_q == MODE_WAIT) |-> (pin_a_q && pin_b_q),
		"motor not stopped while waiting for release")

endmodule

// File: rtl/two_mode_motor_controller.sv
// Top level of the two-mode motor controller: input register, configuration
// registers, stepper and button units, result handshake. Depends on mmc_pkg,
// mmc_stepper, mmc_button and the assertion macros header.
`include "two_mode_motor_controller_macros.svh"

// Takes one control tick per clock cycle while tick_stall is low, and returns
// one result per tick: the tick is first held in the input register, then it
// updates the stepper and button state, which are themselves the result
// register. The input stage stalls only while it holds a tick and a
// finished result is stalled at the output. Configuration writes take effect
// on the next tick and should be made while no tick is in flight.
module two_mode_motor_controller (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       tick_valid,
	output logic                       tick_stall,
	input  mmc_pkg::tick_t             tick,
	output logic                       result_valid,
	input  logic                       result_stall,
	output mmc_pkg::result_t           result,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [mmc_pkg::CfgW-1:0]   cfg_data
);
	import mmc_pkg::*;

	logic              tick_valid_s1;
	tick_t             tick_s1;
	logic              result_valid_q;
	logic [TicksW-1:0] press_limit_q;
	logic [KeyW-1:0]   stop_key_q;
	logic              adv;
	step_status_t      step_status;
	motor_status_t     motor_status;

	// The stored tick moves into the state whenever the result slot is free.
	assign adv        = tick_valid_s1 && (!result_valid_q || !result_stall);
	assign tick_stall = tick_valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_valid_s1 <= 1'b0;
		end else if (!tick_stall) begin
			tick_valid_s1 <= tick_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_valid && !tick_stall) begin
			tick_s1 <= tick;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_limit_q <= PRESS_LIMIT_RST;
			stop_key_q    <= STOP_KEY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PRESS_LIMIT: press_limit_q <= cfg_data;
				CFG_STOP_KEY:    stop_key_q    <= cfg_data[KeyW-1:0];
				default:         ;
			endcase
		end
	end

	mmc_stepper u_stepper (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.keypad_bits (tick_s1.keypad_bits),
		.stop_key    (stop_key_q),
		.status      (step_status)
	);

	mmc_button u_button (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.button_down (tick_s1.button_down),
		.press_limit (press_limit_q),
		.status      (motor_status)
	);

	assign result_valid            = result_valid_q;
	assign result.motor_pin_a      = motor_status.pin_a;
	assign result.motor_pin_b      = motor_status.pin_b;
	assign result.stepper_coils    = step_status.coils;
	assign result.stepper_advanced = step_status.advanced;
	assign result.glyph_select     = motor_status.glyph;
	assign result.mode_now         = motor_status.mode;

	`MMC_ASSERT(a_no_drop, $fell(result_valid_q) |-> !$past(tick_valid_s1),
		"result slot emptied while a tick was waiting")
	`MMC_ASSERT(a_stage_holds, (tick_valid_s1 && result_valid_q && result_stall) |=> tick_valid_s1,
		"stored tick lost while the output was stalled")

endmodule
